FILE: rtl/radix_to_ascii_converter_macros.svh
// -----------------------------------------------------------------------------
// radix_to_ascii_converter_macros
// Assertion macros used by the checker of the radix to ASCII converter.
// -----------------------------------------------------------------------------
`ifndef RADIX_TO_ASCII_CONVERTER_MACROS_SVH
`define RADIX_TO_ASCII_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RTAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RTAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rtac_pkg.sv
// -----------------------------------------------------------------------------
// rtac_pkg
// Types, widths and helper functions of the radix to ASCII converter.
// -----------------------------------------------------------------------------
package rtac_pkg;

   localparam int VALUE_W       = 63;
   localparam int RADIX_W       = 6;
   localparam int CHAR_W        = 7;
   localparam int MAX_DIGITS    = 64;
   localparam int ADDR_W        = $clog2(MAX_DIGITS);
   localparam int CNT_W         = ADDR_W + 1;
   localparam int DIV_W         = VALUE_W + 1;
   localparam int BITS_PER_STEP = 8;
   localparam int DIV_CYCLES    = DIV_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(DIV_CYCLES);

   localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] DECIMAL_BASE = RADIX_W'(10);
   localparam logic [7:0]         ASCII_ZERO   = 8'h30;
   localparam logic [7:0]         ASCII_ALPHA  = 8'd87;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic next;
   } div_ctl_type;

   typedef struct packed {
      logic done;
      logic quot_zero;
   } div_stat_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] radix);
      logic [RADIX_W-1:0] base;
      base = radix;
      if (radix < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      return base;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] digit);
      logic [7:0] sum;
      if (digit < DECIMAL_BASE) begin
         sum = ASCII_ZERO + {2'b00, digit};
      end else begin
         sum = ASCII_ALPHA + {2'b00, digit};
      end
      return sum[CHAR_W-1:0];
   endfunction

endpackage

FILE: rtl/rtac_div.sv
// -----------------------------------------------------------------------------
// rtac_div
// Shared divider: divides the working value by the base, several quotient
// bits per cycle, and keeps the quotient in place for the next digit.
// -----------------------------------------------------------------------------
module rtac_div
   import rtac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_ctl_type        ctl,
   input  logic [VALUE_W-1:0] dividend,
   input  logic [RADIX_W-1:0] divisor,
   output div_stat_type       stat,
   output logic [RADIX_W-1:0] remainder
);

   logic [DIV_W-1:0]         work_ff;
   logic [DIV_W-1:0]         work_in;
   logic [RADIX_W-1:0]       rem_ff;
   logic [RADIX_W-1:0]       rem_in;
   logic [RADIX_W-1:0]       divisor_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     active_ff;
   logic                     done_ff;
   logic [BITS_PER_STEP-1:0] quot_bits;
   logic [RADIX_W-1:0]       rem_next;

   // Restoring division, one quotient bit per inner step. The partial
   // remainder stays below the divisor, so each step is a narrow compare.
   always_comb begin
      logic [RADIX_W:0] trial;
      logic [RADIX_W-1:0] r;
      r = rem_ff;
      quot_bits = '0;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         trial = {r, work_ff[DIV_W-1-i]};
         if (trial >= {1'b0, divisor_ff}) begin
            r = RADIX_W'(trial - {1'b0, divisor_ff});
            quot_bits[BITS_PER_STEP-1-i] = 1'b1;
         end else begin
            r = trial[RADIX_W-1:0];
         end
      end
      rem_next = r;
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      if (ctl.load) begin
         work_in = {1'b0, dividend};
         rem_in  = '0;
      end else if (ctl.next) begin
         rem_in = '0;
      end else if (active_ff) begin
         work_in = {work_ff[DIV_W-BITS_PER_STEP-1:0], quot_bits};
         rem_in  = rem_next;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      if (ctl.load) begin
         divisor_ff <= divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.load || ctl.next) begin
            active_ff <= 1'b1;
            step_ff   <= '0;
         end else if (active_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_CYCLES - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   assign stat.done      = done_ff;
   assign stat.quot_zero = (work_ff == '0);
   assign remainder      = rem_ff;

endmodule

FILE: rtl/rtac_mem.sv
// -----------------------------------------------------------------------------
// rtac_mem
// Digit store: one write port and one registered read port.
// -----------------------------------------------------------------------------
module rtac_mem
   import rtac_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [RADIX_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [RADIX_W-1:0] rd_data
);

   logic [RADIX_W-1:0] store_ff [MAX_DIGITS];
   logic [RADIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/radix_to_ascii_converter.sv
// -----------------------------------------------------------------------------
// radix_to_ascii_converter
// Each digit is the remainder of one pass of the divider over the 64-bit working
// word and is stored as soon as that pass is done; once the quotient is zero, the
// digits are sent as characters, most significant first. A new request is taken
// only in idle, after the last character has been issued; up to 63 digits.
// Characters leave back to back. Synchronous reset returns to idle.
// -----------------------------------------------------------------------------
module radix_to_ascii_converter
   import rtac_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [RADIX_W-1:0] req_radix,
   output logic               rsp_valid,
   output logic [CHAR_W-1:0]  rsp_digit_char,
   output logic               rsp_last_digit
);

   state_type          state_ff;
   state_type          state_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W-1:0]  addr_in;
   logic               issued_ff;
   logic               issued_in;
   logic               last_ff;
   logic               last_in;
   div_ctl_type        div_ctl;
   div_stat_type       div_stat;
   logic [RADIX_W-1:0] div_rem;
   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [RADIX_W-1:0] mem_rd_data;

   rtac_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (req_value),
      .divisor   (clamp_radix(req_radix)),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   rtac_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (div_rem),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         addr_ff   <= '0;
         issued_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         addr_ff   <= addr_in;
         issued_ff <= issued_in;
         last_ff   <= last_in;
      end
   end

   // Division repeats until the quotient is zero, so a zero value still
   // produces the single digit zero. Digits are then read back in reverse.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      issued_in    = 1'b0;
      last_in      = 1'b0;
      div_ctl.load = 1'b0;
      div_ctl.next = 1'b0;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               div_ctl.load = 1'b1;
               count_in     = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               mem_wr_en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               if (div_stat.quot_zero) begin
                  addr_in  = count_ff[ADDR_W-1:0];
                  state_in = ST_EMIT;
               end else begin
                  div_ctl.next = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            mem_rd_en = 1'b1;
            issued_in = 1'b1;
            last_in   = (addr_ff == '0);
            if (addr_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff - ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = issued_ff;
   assign rsp_last_digit = last_ff;
   assign rsp_digit_char = digit_to_ascii(mem_rd_data);

endmodule

FILE: rtl/rtac_checker.sv
// -----------------------------------------------------------------------------
// rtac_checker
// Port-level checks of the radix to ASCII converter, bound to the top level.
// -----------------------------------------------------------------------------
`include "radix_to_ascii_converter_macros.svh"

module rtac_checker
   import rtac_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [CHAR_W-1:0] rsp_digit_char,
   input logic              rsp_last_digit
);

   `RTAC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but block not busy")

   `RTAC_ASSERT_NEXT(a_accept_quiet, start && !busy, !rsp_valid, "character right after a request")

   `RTAC_ASSERT_NEXT(a_chars_contiguous, rsp_valid && !rsp_last_digit, rsp_valid, "gap inside a number")

   `RTAC_ASSERT_NOW(a_char_range, rsp_valid, ((rsp_digit_char >= 7'd48) && (rsp_digit_char <= 7'd57)) || ((rsp_digit_char >= 7'd97) && (rsp_digit_char <= 7'd122)), "character outside the digit set")

endmodule

bind radix_to_ascii_converter rtac_checker u_rtac_checker (.*);
